// ===== rtl/core/fsfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fsfe_pkg;

    // fixed-point format
    localparam int COORD_FRAC_BITS = 14;
    localparam int CW = 16;
    localparam int OW = 20;
    localparam int NW = 4;

    // internal widths: barycentric, second factor, gradient, product
    localparam int LW = ((CW > COORD_FRAC_BITS + 2) ? CW : COORD_FRAC_BITS + 2) + 2;
    localparam int BW = LW + 1;
    localparam int GW = LW + 3;
    localparam int PW = LW + BW;

    localparam logic signed [LW-1:0] ONE_L  = LW'(64'sd1 <<< COORD_FRAC_BITS);
    localparam logic signed [GW-1:0] ONE_G  = GW'(ONE_L);
    localparam logic signed [GW-1:0] HALF_G = GW'(ONE_L >>> 1);

    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_LO = PW'(-(64'sd1 <<< (OW - 1)));

    // rounding offsets for the four shift amounts
    localparam logic signed [PW-1:0] RND_ONE   = PW'(1);
    localparam logic signed [PW-1:0] RND_EDGE  = PW'(64'sd1 <<< (COORD_FRAC_BITS - 3));
    localparam logic signed [PW-1:0] RND_FRAC  = PW'(64'sd1 <<< (COORD_FRAC_BITS - 1));
    localparam logic signed [PW-1:0] RND_FRAC1 = PW'(64'sd1 <<< COORD_FRAC_BITS);

    typedef enum logic [2:0] {
        FORM_LINE1 = 3'd0,
        FORM_LINE2 = 3'd1,
        FORM_TRI1  = 3'd2,
        FORM_TRI2  = 3'd3,
        FORM_TET1  = 3'd4,
        FORM_TET2  = 3'd5,
        FORM_ERR   = 3'd6
    } form_t;

    // right shift applied after the product
    typedef enum logic [1:0] {
        SH_ONE   = 2'd0,
        SH_EDGE  = 2'd1,
        SH_FRAC  = 2'd2,
        SH_FRAC1 = 2'd3
    } shift_t;

    localparam logic [1:0] MODE_LINE = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_TET  = 2'd2;
    localparam logic [1:0] ORD_LIN   = 2'd1;
    localparam logic [1:0] ORD_QUAD  = 2'd2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [1:0]           poly_order;
        logic signed [CW-1:0] coord_xi;
        logic signed [CW-1:0] coord_eta;
        logic signed [CW-1:0] coord_zeta;
    } item_t;

    typedef struct packed {
        logic [NW-1:0]        node_index;
        logic signed [OW-1:0] shape_value;
        logic signed [OW-1:0] grad_xi;
        logic signed [OW-1:0] grad_eta;
        logic signed [OW-1:0] grad_zeta;
        logic                 last_node;
        logic                 error_flag;
    } result_t;

    // control travelling with each node down the pipeline
    typedef struct packed {
        logic          valid;
        form_t         form;
        logic [NW-1:0] node;
        logic          last;
    } ctl_t;

    function automatic form_t decode_form(input logic [1:0] mode, input logic [1:0] ord);
        form_t f;
        f = FORM_ERR;
        if (ord == ORD_LIN || ord == ORD_QUAD)
        begin
            if (mode == MODE_LINE)
                f = (ord == ORD_LIN) ? FORM_LINE1 : FORM_LINE2;
            else if (mode == MODE_TRI)
                f = (ord == ORD_LIN) ? FORM_TRI1 : FORM_TRI2;
            else if (mode == MODE_TET)
                f = (ord == ORD_LIN) ? FORM_TET1 : FORM_TET2;
        end
        return f;
    endfunction

    function automatic logic [NW-1:0] last_index(input form_t f);
        logic [NW-1:0] n;
        unique case (f)
            FORM_LINE1: n = NW'(1);
            FORM_LINE2: n = NW'(2);
            FORM_TRI1:  n = NW'(2);
            FORM_TRI2:  n = NW'(5);
            FORM_TET1:  n = NW'(3);
            FORM_TET2:  n = NW'(9);
            default:    n = NW'(0);
        endcase
        return n;
    endfunction

    function automatic logic signed [OW-1:0] sat_out(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        c = v;
        if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        return c[OW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fsfe_node_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsfe_node_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire fsfe_pkg::item_t item,
    output logic                 busy,
    output fsfe_pkg::ctl_t       ctl,
    output fsfe_pkg::item_t      held
);

    logic                      active_reg, active_next;
    fsfe_pkg::form_t           form_reg, form_next;
    logic [fsfe_pkg::NW-1:0]   node_reg, node_next;
    fsfe_pkg::item_t           item_reg, item_next;
    logic                      last;
    logic                      accept;

    assign last   = (node_reg == fsfe_pkg::last_index(form_reg));
    assign busy   = active_reg && !last;
    assign accept = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        form_next   = form_reg;
        node_next   = node_reg;
        item_next   = item_reg;
        if (accept)
        begin
            active_next = 1'b1;
            form_next   = fsfe_pkg::decode_form(item.mode, item.poly_order);
            node_next   = '0;
            item_next   = item;
        end
        else if (active_reg)
        begin
            if (last)
                active_next = 1'b0;
            else
                node_next = node_reg + fsfe_pkg::NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            form_reg   <= fsfe_pkg::FORM_ERR;
            node_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            form_reg   <= form_next;
            node_reg   <= node_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign ctl.valid = active_reg;
    assign ctl.form  = form_reg;
    assign ctl.node  = node_reg;
    assign ctl.last  = last;
    assign held      = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fsfe_bary.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsfe_bary (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fsfe_pkg::ctl_t              ctl_in,
    input  wire fsfe_pkg::item_t             held,
    output fsfe_pkg::ctl_t                   ctl_out,
    output logic signed [fsfe_pkg::LW-1:0]   l1,
    output logic signed [fsfe_pkg::LW-1:0]   l2,
    output logic signed [fsfe_pkg::LW-1:0]   l3,
    output logic signed [fsfe_pkg::LW-1:0]   l4
);

    fsfe_pkg::ctl_t                 ctl_reg;
    logic signed [fsfe_pkg::LW-1:0] l1_reg, l1_next;
    logic signed [fsfe_pkg::LW-1:0] l2_reg, l3_reg, l4_reg;
    logic signed [fsfe_pkg::LW-1:0] e, z;
    logic                           is_line, is_tet;

    always_comb
    begin
        is_line = (ctl_in.form == fsfe_pkg::FORM_LINE1) || (ctl_in.form == fsfe_pkg::FORM_LINE2);
        is_tet  = (ctl_in.form == fsfe_pkg::FORM_TET1) || (ctl_in.form == fsfe_pkg::FORM_TET2);
        e = is_line ? '0 : fsfe_pkg::LW'(held.coord_eta);
        z = is_tet ? fsfe_pkg::LW'(held.coord_zeta) : '0;
        l1_next = fsfe_pkg::ONE_L - fsfe_pkg::LW'(held.coord_xi) - e - z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        l1_reg <= l1_next;
        l2_reg <= fsfe_pkg::LW'(held.coord_xi);
        l3_reg <= fsfe_pkg::LW'(held.coord_eta);
        l4_reg <= fsfe_pkg::LW'(held.coord_zeta);
    end

    assign ctl_out = ctl_reg;
    assign l1 = l1_reg;
    assign l2 = l2_reg;
    assign l3 = l3_reg;
    assign l4 = l4_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fsfe_term.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsfe_term (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fsfe_pkg::ctl_t              ctl_in,
    input  wire logic signed [fsfe_pkg::LW-1:0] l1,
    input  wire logic signed [fsfe_pkg::LW-1:0] l2,
    input  wire logic signed [fsfe_pkg::LW-1:0] l3,
    input  wire logic signed [fsfe_pkg::LW-1:0] l4,
    output fsfe_pkg::ctl_t                   ctl_out,
    output logic signed [fsfe_pkg::LW-1:0]   op_a,
    output logic signed [fsfe_pkg::BW-1:0]   op_b,
    output fsfe_pkg::shift_t                 shift,
    output logic signed [fsfe_pkg::GW-1:0]   gx,
    output logic signed [fsfe_pkg::GW-1:0]   gy,
    output logic signed [fsfe_pkg::GW-1:0]   gz
);

    localparam int LW = fsfe_pkg::LW;
    localparam int BW = fsfe_pkg::BW;
    localparam int GW = fsfe_pkg::GW;

    fsfe_pkg::ctl_t         ctl_reg;
    logic signed [LW-1:0]   a_reg, a_next;
    logic signed [BW-1:0]   b_reg, b_next;
    fsfe_pkg::shift_t       sh_reg, sh_next;
    logic signed [GW-1:0]   gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;

    logic signed [LW-1:0]   lv [4];
    logic signed [LW-1:0]   lsel;
    logic signed [BW-1:0]   one_b;
    logic signed [GW-1:0]   q1, q2, q3, q4, xg;

    always_comb
    begin
        lv[0] = l1;
        lv[1] = l2;
        lv[2] = l3;
        lv[3] = l4;
        lsel  = lv[ctl_in.node[1:0]];
        one_b = BW'(fsfe_pkg::ONE_L);
        q1 = GW'(l1) <<< 2;
        q2 = GW'(l2) <<< 2;
        q3 = GW'(l3) <<< 2;
        q4 = GW'(l4) <<< 2;
        xg = GW'(l2);

        a_next  = '0;
        b_next  = '0;
        sh_next = fsfe_pkg::SH_FRAC;
        gx_next = '0;
        gy_next = '0;
        gz_next = '0;

        unique case (ctl_in.form)
            fsfe_pkg::FORM_LINE1:
            begin
                sh_next = fsfe_pkg::SH_ONE;
                b_next  = BW'(1);
                if (ctl_in.node == '0)
                begin
                    a_next  = fsfe_pkg::ONE_L - l2;
                    gx_next = -fsfe_pkg::HALF_G;
                end
                else
                begin
                    a_next  = fsfe_pkg::ONE_L + l2;
                    gx_next = fsfe_pkg::HALF_G;
                end
            end
            fsfe_pkg::FORM_LINE2:
            begin
                unique case (ctl_in.node)
                    fsfe_pkg::NW'(0):
                    begin
                        a_next  = l2;
                        b_next  = BW'(l2) - one_b;
                        sh_next = fsfe_pkg::SH_FRAC1;
                        gx_next = xg - fsfe_pkg::HALF_G;
                    end
                    fsfe_pkg::NW'(1):
                    begin
                        a_next  = l2;
                        b_next  = BW'(l2) + one_b;
                        sh_next = fsfe_pkg::SH_FRAC1;
                        gx_next = xg + fsfe_pkg::HALF_G;
                    end
                    default:
                    begin
                        a_next  = fsfe_pkg::ONE_L - l2;
                        b_next  = one_b + BW'(l2);
                        gx_next = -(xg <<< 1);
                    end
                endcase
            end
            fsfe_pkg::FORM_TRI1, fsfe_pkg::FORM_TET1:
            begin
                // linear: N is the barycentric coordinate itself
                a_next = lsel;
                b_next = one_b;
                unique case (ctl_in.node)
                    fsfe_pkg::NW'(0):
                    begin
                        gx_next = -fsfe_pkg::ONE_G;
                        gy_next = -fsfe_pkg::ONE_G;
                        if (ctl_in.form == fsfe_pkg::FORM_TET1)
                            gz_next = -fsfe_pkg::ONE_G;
                    end
                    fsfe_pkg::NW'(1): gx_next = fsfe_pkg::ONE_G;
                    fsfe_pkg::NW'(2): gy_next = fsfe_pkg::ONE_G;
                    default:          gz_next = fsfe_pkg::ONE_G;
                endcase
            end
            fsfe_pkg::FORM_TRI2:
            begin
                unique case (ctl_in.node)
                    fsfe_pkg::NW'(0), fsfe_pkg::NW'(1), fsfe_pkg::NW'(2):
                    begin
                        a_next = lsel;
                        b_next = (BW'(lsel) <<< 1) - one_b;
                        unique case (ctl_in.node[1:0])
                            2'd0:
                            begin
                                gx_next = fsfe_pkg::ONE_G - q1;
                                gy_next = fsfe_pkg::ONE_G - q1;
                            end
                            2'd1:    gx_next = q2 - fsfe_pkg::ONE_G;
                            default: gy_next = q3 - fsfe_pkg::ONE_G;
                        endcase
                    end
                    fsfe_pkg::NW'(3):
                    begin
                        a_next  = l1;
                        b_next  = BW'(l2);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = q1 - q2;
                        gy_next = -q2;
                    end
                    fsfe_pkg::NW'(4):
                    begin
                        a_next  = l2;
                        b_next  = BW'(l3);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = q3;
                        gy_next = q2;
                    end
                    default:
                    begin
                        a_next  = l3;
                        b_next  = BW'(l1);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = -q3;
                        gy_next = q1 - q3;
                    end
                endcase
            end
            fsfe_pkg::FORM_TET2:
            begin
                unique case (ctl_in.node)
                    fsfe_pkg::NW'(0), fsfe_pkg::NW'(1), fsfe_pkg::NW'(2), fsfe_pkg::NW'(3):
                    begin
                        a_next = lsel;
                        b_next = (BW'(lsel) <<< 1) - one_b;
                        unique case (ctl_in.node[1:0])
                            2'd0:
                            begin
                                gx_next = fsfe_pkg::ONE_G - q1;
                                gy_next = fsfe_pkg::ONE_G - q1;
                                gz_next = fsfe_pkg::ONE_G - q1;
                            end
                            2'd1:    gx_next = q2 - fsfe_pkg::ONE_G;
                            2'd2:    gy_next = q3 - fsfe_pkg::ONE_G;
                            default: gz_next = q4 - fsfe_pkg::ONE_G;
                        endcase
                    end
                    fsfe_pkg::NW'(4):
                    begin
                        a_next  = l1;
                        b_next  = BW'(l2);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = q1 - q2;
                        gy_next = -q2;
                        gz_next = -q2;
                    end
                    fsfe_pkg::NW'(5):
                    begin
                        a_next  = l1;
                        b_next  = BW'(l3);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = -q3;
                        gy_next = q1 - q3;
                        gz_next = -q3;
                    end
                    fsfe_pkg::NW'(6):
                    begin
                        a_next  = l1;
                        b_next  = BW'(l4);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = -q4;
                        gy_next = -q4;
                        gz_next = q1 - q4;
                    end
                    fsfe_pkg::NW'(7):
                    begin
                        a_next  = l2;
                        b_next  = BW'(l3);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = q3;
                        gy_next = q2;
                    end
                    fsfe_pkg::NW'(8):
                    begin
                        a_next  = l2;
                        b_next  = BW'(l4);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gx_next = q4;
                        gz_next = q2;
                    end
                    default:
                    begin
                        a_next  = l3;
                        b_next  = BW'(l4);
                        sh_next = fsfe_pkg::SH_EDGE;
                        gy_next = q4;
                        gz_next = q3;
                    end
                endcase
            end
            default:
            begin
                // unsupported kind or order: all zero
                a_next = '0;
                b_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        sh_reg <= sh_next;
        gx_reg <= gx_next;
        gy_reg <= gy_next;
        gz_reg <= gz_next;
    end

    assign ctl_out = ctl_reg;
    assign op_a    = a_reg;
    assign op_b    = b_reg;
    assign shift   = sh_reg;
    assign gx      = gx_reg;
    assign gy      = gy_reg;
    assign gz      = gz_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fsfe_mul_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsfe_mul_round (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fsfe_pkg::ctl_t                 ctl_in,
    input  wire logic signed [fsfe_pkg::LW-1:0] op_a,
    input  wire logic signed [fsfe_pkg::BW-1:0] op_b,
    input  wire fsfe_pkg::shift_t               shift,
    input  wire logic signed [fsfe_pkg::GW-1:0] gx,
    input  wire logic signed [fsfe_pkg::GW-1:0] gy,
    input  wire logic signed [fsfe_pkg::GW-1:0] gz,
    output logic                                strobe,
    output fsfe_pkg::result_t                   result
);

    localparam int PW = fsfe_pkg::PW;
    localparam int GW = fsfe_pkg::GW;
    localparam int F  = fsfe_pkg::COORD_FRAC_BITS;

    // stage 3: product
    fsfe_pkg::ctl_t        ctl3_reg;
    logic signed [PW-1:0]  prod_reg, prod_next;
    fsfe_pkg::shift_t      sh3_reg;
    logic signed [GW-1:0]  gx3_reg, gy3_reg, gz3_reg;

    // stage 4: round, saturate, output register
    logic                  strobe_reg;
    fsfe_pkg::result_t     res_reg, res_next;
    logic signed [PW-1:0]  rnd;

    assign prod_next = PW'(op_a) * PW'(op_b);

    always_comb
    begin
        unique case (sh3_reg)
            fsfe_pkg::SH_ONE:   rnd = (prod_reg + fsfe_pkg::RND_ONE) >>> 1;
            fsfe_pkg::SH_EDGE:  rnd = (prod_reg + fsfe_pkg::RND_EDGE) >>> (F - 2);
            fsfe_pkg::SH_FRAC:  rnd = (prod_reg + fsfe_pkg::RND_FRAC) >>> F;
            default:            rnd = (prod_reg + fsfe_pkg::RND_FRAC1) >>> (F + 1);
        endcase

        res_next.node_index  = ctl3_reg.node;
        res_next.shape_value = fsfe_pkg::sat_out(rnd);
        res_next.grad_xi     = fsfe_pkg::sat_out(PW'(gx3_reg));
        res_next.grad_eta    = fsfe_pkg::sat_out(PW'(gy3_reg));
        res_next.grad_zeta   = fsfe_pkg::sat_out(PW'(gz3_reg));
        res_next.last_node   = ctl3_reg.last;
        res_next.error_flag  = (ctl3_reg.form == fsfe_pkg::FORM_ERR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            ctl3_reg   <= ctl_in;
            strobe_reg <= ctl3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sh3_reg  <= shift;
        gx3_reg  <= gx;
        gy3_reg  <= gy;
        gz3_reg  <= gz;
        res_reg  <= res_next;
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fem_shape_function_evaluator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// lagrange shape functions (p1/p2) for line, triangle and tetrahedron elements
// input channel: a transaction is taken at a clock edge with start high and busy low;
//   item carries element kind, order and the reference coordinates xi, eta, zeta
// output channel: one result transaction per node, in standard node order, each
//   shown for exactly one cycle with result_strobe high; last_node marks the final one
// an unsupported kind or order gives one result with error_flag and last_node set
// a node sequencer issues one node per cycle into a four-stage pipeline:
//   barycentric coordinates, operand and gradient selection, product, round/saturate
// the first result comes once node zero has passed every stage; then one node per cycle follows
// a transaction has 1, 2, 3, 4, 6 or 10 nodes; busy drops
//   in the cycle the last node issues, so the next transaction follows without a gap
// the sequencer's node counter paces the transactions: one pipeline slot per node
// the receiver cannot stall; results are never held back
// reset clears the sequencer and pipeline valid bits; no result in flight survives it
module fem_shape_function_evaluator_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire fsfe_pkg::item_t   item,
    output logic                   busy,
    output logic                   result_strobe,
    output fsfe_pkg::result_t      result
);

    // sequencer to barycentric stage
    fsfe_pkg::ctl_t                 seq_ctl;
    fsfe_pkg::item_t                seq_item;

    // barycentric stage to operand stage
    fsfe_pkg::ctl_t                 bar_ctl;
    logic signed [fsfe_pkg::LW-1:0] l1, l2, l3, l4;

    // operand stage to multiply and round
    fsfe_pkg::ctl_t                 trm_ctl;
    logic signed [fsfe_pkg::LW-1:0] op_a;
    logic signed [fsfe_pkg::BW-1:0] op_b;
    fsfe_pkg::shift_t               shift;
    logic signed [fsfe_pkg::GW-1:0] gx, gy, gz;

    // node sequencer: holds the transaction, counts its nodes
    fsfe_node_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .ctl   (seq_ctl),
        .held  (seq_item)
    );

    // stage 1: barycentric coordinates l1..l4
    fsfe_bary u_bary (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (seq_ctl),
        .held    (seq_item),
        .ctl_out (bar_ctl),
        .l1      (l1),
        .l2      (l2),
        .l3      (l3),
        .l4      (l4)
    );

    // stage 2: product operands, shift and gradients for the node
    fsfe_term u_term (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (bar_ctl),
        .l1      (l1),
        .l2      (l2),
        .l3      (l3),
        .l4      (l4),
        .ctl_out (trm_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .shift   (shift),
        .gx      (gx),
        .gy      (gy),
        .gz      (gz)
    );

    // stages 3 and 4: multiply, then round half up and saturate into the output register
    fsfe_mul_round u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (trm_ctl),
        .op_a   (op_a),
        .op_b   (op_b),
        .shift  (shift),
        .gx     (gx),
        .gy     (gy),
        .gz     (gz),
        .strobe (result_strobe),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fsfe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsfe_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              result_strobe,
    input wire fsfe_pkg::result_t result
);

    // an error result stands alone as node zero
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.error_flag |-> result.last_node && (result.node_index == '0))
    else $error("error result not a single last node");

    // nodes of one transaction leave back to back and in order
    a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last_node
        |=> result_strobe && (result.node_index == $past(result.node_index) + 4'd1))
    else $error("node results not consecutive");

    // the first node leaves the block after every acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 (result_strobe && (result.node_index == '0)))
    else $error("first node missing after acceptance");

    // no first node without an accepted transaction
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (result.node_index == '0) |-> $past(start && !busy, 5))
    else $error("first node without accepted transaction");

endmodule

bind fem_shape_function_evaluator_core fsfe_checker u_fsfe_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // input codes the package leaves unnamed: all three are error cases
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] ORD_NONE  = 2'd0;
    localparam logic [1:0] ORD_HIGH  = 2'd3;

    // coordinate corners in q2.14
    localparam logic signed [fsfe_pkg::CW-1:0] C_ZERO = 16'sh0000;
    localparam logic signed [fsfe_pkg::CW-1:0] C_QTR  = 16'sh1000;
    localparam logic signed [fsfe_pkg::CW-1:0] C_HALF = 16'sh2000;
    localparam logic signed [fsfe_pkg::CW-1:0] C_ONE  = 16'sh4000;
    localparam logic signed [fsfe_pkg::CW-1:0] C_NEG1 = 16'shc000;
    localparam logic signed [fsfe_pkg::CW-1:0] C_MAX  = 16'sh7fff;
    localparam logic signed [fsfe_pkg::CW-1:0] C_MIN  = 16'sh8000;

    localparam longint OUT_HI = 524287;
    localparam longint OUT_LO = -524288;

    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    // the one result an unsupported kind or order produces
    localparam fsfe_pkg::result_t ERR_NODE = '{
        node_index: '0, shape_value: '0, grad_xi: '0, grad_eta: '0, grad_zeta: '0,
        last_node: 1'b1, error_flag: 1'b1
    };
    localparam fsfe_pkg::result_t NO_NODE = '0;

    typedef struct packed {
        fsfe_pkg::item_t   stim;
        logic              typed;      // expectation written out below, else from the predictor
        fsfe_pkg::result_t typed_res;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;

    // directed transactions: error codes first, then every form at its corners
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{'{MODE_NONE,          fsfe_pkg::ORD_LIN,  C_ZERO, C_ZERO, C_ZERO}, 1'b1, ERR_NODE},
        '{'{fsfe_pkg::MODE_LINE, ORD_NONE,          C_MAX,  C_MIN,  C_MAX},  1'b1, ERR_NODE},
        '{'{fsfe_pkg::MODE_TRI,  ORD_HIGH,          C_MIN,  C_MAX,  C_MIN},  1'b1, ERR_NODE},
        '{'{fsfe_pkg::MODE_TET,  ORD_NONE,          C_ONE,  C_ONE,  C_ONE},  1'b1, ERR_NODE},
        '{'{MODE_NONE,          ORD_HIGH,          C_MIN,  C_MIN,  C_MIN},  1'b1, ERR_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_LIN,  C_ZERO, C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_LIN,  C_MIN,  C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_LIN,  C_MAX,  C_MIN,  C_MAX},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_QUAD, C_NEG1, C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_QUAD, C_MIN,  C_MAX,  C_MIN},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_QUAD, C_MAX,  C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_LINE, fsfe_pkg::ORD_QUAD, C_HALF, C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_LIN,  C_ZERO, C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_LIN,  C_MAX,  C_MAX,  C_MIN},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_LIN,  C_MIN,  C_MIN,  C_MAX},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_QUAD, C_ZERO, C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_QUAD, C_HALF, C_HALF, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_QUAD, C_MIN,  C_MIN,  C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TRI,  fsfe_pkg::ORD_QUAD, C_MAX,  C_MIN,  C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TET,  fsfe_pkg::ORD_LIN,  C_ZERO, C_ZERO, C_ZERO}, 1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TET,  fsfe_pkg::ORD_LIN,  C_MIN,  C_MIN,  C_MIN},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TET,  fsfe_pkg::ORD_QUAD, C_QTR,  C_QTR,  C_QTR},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TET,  fsfe_pkg::ORD_QUAD, C_MIN,  C_MIN,  C_MIN},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TET,  fsfe_pkg::ORD_QUAD, C_MAX,  C_MAX,  C_MAX},  1'b0, NO_NODE},
        '{'{fsfe_pkg::MODE_TET,  fsfe_pkg::ORD_QUAD, C_ONE,  C_ZERO, C_ZERO}, 1'b0, NO_NODE}
    };

    // block ports; the driven inputs are all known from time zero
    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    fsfe_pkg::item_t   item  = '0;
    logic              busy;
    logic              result_strobe;
    fsfe_pkg::result_t result;

    // node results still owed by the block, oldest first
    fsfe_pkg::result_t expected_nodes [$];
    fsfe_pkg::result_t oldest_node;
    int                mismatches  = 0;
    int unsigned       cycle_count = 0;

    fem_shape_function_evaluator_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // floor(v / 2^s + 1/2): add half an lsb, then an arithmetic shift floors
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [fsfe_pkg::OW-1:0] clamp_out(input longint v);
        if (v > OUT_HI)
            v = OUT_HI;
        else if (v < OUT_LO)
            v = OUT_LO;
        return fsfe_pkg::OW'(v);
    endfunction

    // vertex function l(2l - 1) and edge function 4 la lb, back in q.f
    function automatic longint vertex_fn(input longint l, input longint one);
        return round_shift(l * (2 * l - one), fsfe_pkg::COORD_FRAC_BITS);
    endfunction

    function automatic longint edge_fn(input longint a, input longint b);
        return round_shift(4 * a * b, fsfe_pkg::COORD_FRAC_BITS);
    endfunction

    // works out every node result of one transaction and queues it
    task automatic predict_nodes(input fsfe_pkg::item_t it);
        longint            one, xi, eta, zeta, l1, l2, l3, l4, d0;
        longint            n [10];
        longint            gx [10];
        longint            gy [10];
        longint            gz [10];
        int                cnt;
        fsfe_pkg::result_t r;
        one  = longint'(1) <<< fsfe_pkg::COORD_FRAC_BITS;
        xi   = longint'($signed(it.coord_xi));
        eta  = longint'($signed(it.coord_eta));
        zeta = longint'($signed(it.coord_zeta));
        cnt  = 0;
        for (int k = 0; k < 10; k++)
        begin
            n[k] = 0; gx[k] = 0; gy[k] = 0; gz[k] = 0;
        end
        if (it.mode == fsfe_pkg::MODE_LINE && it.poly_order == fsfe_pkg::ORD_LIN)
        begin
            cnt   = 2;
            n[0]  = round_shift(one - xi, 1);
            n[1]  = round_shift(one + xi, 1);
            gx[0] = -(one >>> 1);
            gx[1] = one >>> 1;
        end
        else if (it.mode == fsfe_pkg::MODE_LINE && it.poly_order == fsfe_pkg::ORD_QUAD)
        begin
            cnt   = 3;
            n[0]  = round_shift(xi * (xi - one), fsfe_pkg::COORD_FRAC_BITS + 1);
            n[1]  = round_shift(xi * (xi + one), fsfe_pkg::COORD_FRAC_BITS + 1);
            n[2]  = round_shift((one - xi) * (one + xi), fsfe_pkg::COORD_FRAC_BITS);
            gx[0] = xi - (one >>> 1);
            gx[1] = xi + (one >>> 1);
            gx[2] = -2 * xi;
        end
        else if (it.mode == fsfe_pkg::MODE_TRI && it.poly_order == fsfe_pkg::ORD_LIN)
        begin
            cnt   = 3;
            n[0]  = one - xi - eta;
            n[1]  = xi;
            n[2]  = eta;
            gx[0] = -one; gy[0] = -one;
            gx[1] = one;
            gy[2] = one;
        end
        else if (it.mode == fsfe_pkg::MODE_TRI && it.poly_order == fsfe_pkg::ORD_QUAD)
        begin
            l1 = one - xi - eta;
            l2 = xi;
            l3 = eta;
            cnt  = 6;
            n[0] = vertex_fn(l1, one);
            n[1] = vertex_fn(l2, one);
            n[2] = vertex_fn(l3, one);
            n[3] = edge_fn(l1, l2);
            n[4] = edge_fn(l2, l3);
            n[5] = edge_fn(l3, l1);
            gx[0] = one - 4 * l1;   gy[0] = one - 4 * l1;
            gx[1] = 4 * l2 - one;
            gy[2] = 4 * l3 - one;
            gx[3] = 4 * (l1 - l2);  gy[3] = -4 * l2;
            gx[4] = 4 * l3;         gy[4] = 4 * l2;
            gx[5] = -4 * l3;        gy[5] = 4 * (l1 - l3);
        end
        else if (it.mode == fsfe_pkg::MODE_TET && it.poly_order == fsfe_pkg::ORD_LIN)
        begin
            cnt   = 4;
            n[0]  = one - xi - eta - zeta;
            n[1]  = xi;
            n[2]  = eta;
            n[3]  = zeta;
            gx[0] = -one; gy[0] = -one; gz[0] = -one;
            gx[1] = one;
            gy[2] = one;
            gz[3] = one;
        end
        else if (it.mode == fsfe_pkg::MODE_TET && it.poly_order == fsfe_pkg::ORD_QUAD)
        begin
            l1 = one - xi - eta - zeta;
            l2 = xi;
            l3 = eta;
            l4 = zeta;
            d0 = one - 4 * l1;
            cnt  = 10;
            n[0] = vertex_fn(l1, one);
            n[1] = vertex_fn(l2, one);
            n[2] = vertex_fn(l3, one);
            n[3] = vertex_fn(l4, one);
            n[4] = edge_fn(l1, l2);
            n[5] = edge_fn(l1, l3);
            n[6] = edge_fn(l1, l4);
            n[7] = edge_fn(l2, l3);
            n[8] = edge_fn(l2, l4);
            n[9] = edge_fn(l3, l4);
            gx[0] = d0; gy[0] = d0; gz[0] = d0;
            gx[1] = 4 * l2 - one;
            gy[2] = 4 * l3 - one;
            gz[3] = 4 * l4 - one;
            gx[4] = 4 * (l1 - l2); gy[4] = -4 * l2;        gz[4] = -4 * l2;
            gx[5] = -4 * l3;       gy[5] = 4 * (l1 - l3);  gz[5] = -4 * l3;
            gx[6] = -4 * l4;       gy[6] = -4 * l4;        gz[6] = 4 * (l1 - l4);
            gx[7] = 4 * l3;        gy[7] = 4 * l2;
            gx[8] = 4 * l4;        gz[8] = 4 * l2;
            gy[9] = 4 * l4;        gz[9] = 4 * l3;
        end
        if (cnt == 0)
            expected_nodes.push_back(ERR_NODE);
        for (int k = 0; k < cnt; k++)
        begin
            r.node_index  = fsfe_pkg::NW'(k);
            r.shape_value = clamp_out(n[k]);
            r.grad_xi     = clamp_out(gx[k]);
            r.grad_eta    = clamp_out(gy[k]);
            r.grad_zeta   = clamp_out(gz[k]);
            r.last_node   = (k == cnt - 1);
            r.error_flag  = 1'b0;
            expected_nodes.push_back(r);
        end
    endtask

    // coordinates: whole range, inside the element, around it, or a corner
    function automatic logic signed [fsfe_pkg::CW-1:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return fsfe_pkg::CW'($urandom);
            1:       return fsfe_pkg::CW'($urandom_range(0, 16384));
            2:       return fsfe_pkg::CW'(int'($urandom_range(0, 32768)) - 16384);
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return C_ONE;
                    3:       return C_NEG1;
                    default: return C_ZERO;
                endcase
            end
        endcase
    endfunction

    // mostly supported forms, about one in ten an unsupported kind or order
    function automatic fsfe_pkg::item_t random_item();
        fsfe_pkg::item_t it;
        if ($urandom_range(0, 9) == 0)
        begin
            it.mode       = 2'($urandom_range(0, 3));
            it.poly_order = 2'($urandom_range(0, 3));
            if (it.poly_order == fsfe_pkg::ORD_LIN || it.poly_order == fsfe_pkg::ORD_QUAD)
                it.mode = MODE_NONE;
        end
        else
        begin
            it.mode       = 2'($urandom_range(0, 2));
            it.poly_order = 2'($urandom_range(1, 2));
        end
        it.coord_xi   = random_coord();
        it.coord_eta  = random_coord();
        it.coord_zeta = random_coord();
        return it;
    endfunction

    // idle gap: often none, mostly short, now and then long
    function automatic int pause_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // presents one transaction and holds it until the block takes it
    // busy is read just after the edge, so it is the value that edge saw
    task automatic issue(input fsfe_pkg::item_t it, input logic typed,
                         input fsfe_pkg::result_t typed_res);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
            expected_nodes.push_back(typed_res);
        else
            predict_nodes(it);
    endtask

    // drops start for a while; a zero gap keeps start high for the next transaction
    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: the receiver cannot stall, so every strobe is a transaction
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_nodes.size() == 0)
            begin
                $display("%0t unexpected result transaction: expected none, actual %h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                oldest_node = expected_nodes.pop_front();
                check_field("node_index", oldest_node.node_index, result.node_index);
                check_field("shape_value", $signed(oldest_node.shape_value),
                            $signed(result.shape_value));
                check_field("grad_xi", $signed(oldest_node.grad_xi), $signed(result.grad_xi));
                check_field("grad_eta", $signed(oldest_node.grad_eta),
                            $signed(result.grad_eta));
                check_field("grad_zeta", $signed(oldest_node.grad_zeta),
                            $signed(result.grad_zeta));
                check_field("last_node", oldest_node.last_node, result.last_node);
                check_field("error_flag", oldest_node.error_flag, result.error_flag);
            end
        end
    end

    // watchdog, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic steady;
        steady = 1'b0;

        // reset held low, then released on an edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue(directed_table[i].stim, directed_table[i].typed, directed_table[i].typed_res);
            idle_for(pause_len());
        end

        // random transactions, with stretches of back-to-back traffic
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            issue(random_item(), 1'b0, NO_NODE);
            idle_for(steady ? 0 : pause_len());
        end
        start <= 1'b0;

        // drain, then give any stray result time to show
        while (expected_nodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
